// ===== rtl/core/periodic_task_slot_scheduler_defines.svh =====
// Assertion macros for the periodic task slot scheduler.
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check under reset gating on aclk/aresetn.
`define PTSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check that also holds while reset is asserted.
`define PTSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PTSS_ASSERT(lbl, prop, msg)
`define PTSS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/ptss_pkg.sv =====
package ptss_pkg;

    // Command codes (s_tuser)
    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_DISPATCH = 2'd1;
    localparam logic [1:0] CMD_CREATE   = 2'd2;
    localparam logic [1:0] CMD_DELETE   = 2'd3;

    // Task types on create
    localparam logic [1:0] TYPE_CYCLE   = 2'd0;
    localparam logic [1:0] TYPE_HANDLER = 2'd1;
    localparam logic [1:0] TYPE_ONCE    = 2'd2;
    // create type outside the legal range
    localparam logic [1:0] TYPE_BAD     = 2'd3;

    // Slot modes
    typedef logic [2:0] mode_t;
    localparam mode_t MODE_DEL     = 3'd0;
    localparam mode_t MODE_CYCLE   = 3'd1;
    localparam mode_t MODE_HANDLER = 3'd2;
    localparam mode_t MODE_ONCE    = 3'd3;
    localparam mode_t MODE_READY   = 3'd4;

    // Result kinds (m_tuser)
    localparam logic EV_RUN  = 1'b0;
    localparam logic EV_DONE = 1'b1;

    // Port widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 1;

    localparam int HANDLE_W = 16;
    localparam int PERIOD_W = 16;
    localparam int CD_W     = 17;
    localparam int SLOT_W   = 3;

endpackage

// ===== rtl/core/periodic_task_slot_scheduler.sv =====
// Each command is accepted while idle; the single slot-update unit then walks the slots
//   in order, up to the in-use count (all SLOTS for a create, none for a bad create type),
//   stopping where a create or delete finds its slot, and the finish state registers the result.
// s_tready is high only while idle; output stalls on m_tready hold the slot walk in place.
// Reset (aresetn low, synchronous): all slots free and deleted, in-use count zero, no result.
module periodic_task_slot_scheduler #(
    parameter int SLOTS = 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] task_handle, [31:16] period, [33:32] task_type, [39:34] zero
    input  logic [ptss_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] cmd
    input  logic [ptss_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] run_handle, [18:16] slot_index, [19] success, [23:20] zero
    output logic [ptss_pkg::M_TDATA_W-1:0]    m_tdata,
    // [0] event_res
    output logic [ptss_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                              m_tlast
);
    import ptss_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    // Slot table
    logic                valid_reg  [SLOTS];
    mode_t               mode_reg   [SLOTS];
    logic [HANDLE_W-1:0] handle_reg [SLOTS];
    logic [CD_W-1:0]     cd_reg     [SLOTS];
    logic [PERIOD_W-1:0] period_reg [SLOTS];

    // Sequencer and command latch
    logic [1:0]          state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       end_reg, end_next;
    logic [CW-1:0]       siu_reg, siu_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [HANDLE_W-1:0] hdl_reg, hdl_next;
    logic [PERIOD_W-1:0] per_reg, per_next;
    logic [1:0]          typ_reg, typ_next;
    logic                ok_reg, ok_next;
    logic [IW-1:0]       where_reg, where_next;

    // Output register
    logic                mv_reg, mv_next;
    logic                mev_reg, mev_next;
    logic [HANDLE_W-1:0] mhdl_reg, mhdl_next;
    logic [SLOT_W-1:0]   mslot_reg, mslot_next;
    logic                mok_reg, mok_next;
    logic                mlast_reg, mlast_next;

    // Slot write port
    logic                we_valid, valid_d;
    logic                we_mode;
    mode_t               mode_d;
    logic                we_cd;
    logic [CD_W-1:0]     cd_d;
    logic                we_cfg;

    logic                out_free;
    logic                last_step;
    logic                found;
    logic [CD_W-1:0]     cd_dec;
    mode_t               cur_mode;
    logic [1:0]          in_typ;
    logic [CW-1:0]       in_end;

    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !mv_reg || m_tready;
    assign cur_mode  = mode_reg[idx_reg];
    assign cd_dec    = cd_reg[idx_reg] - CD_W'(1);
    assign last_step = (CW'(idx_reg) + CW'(1)) == end_reg;
    assign in_typ    = s_tdata[33:32];

    // Walk length fixed at accept
    always_comb begin
        if (s_tuser == CMD_CREATE) begin
            in_end = (in_typ == TYPE_BAD) ? '0 : CW'(SLOTS);
        end else begin
            in_end = siu_reg;
        end
    end

    // Sequencer and slot update unit
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        end_next   = end_reg;
        siu_next   = siu_reg;
        cmd_next   = cmd_reg;
        hdl_next   = hdl_reg;
        per_next   = per_reg;
        typ_next   = typ_reg;
        ok_next    = ok_reg;
        where_next = where_reg;

        mv_next    = mv_reg && !m_tready;
        mev_next   = mev_reg;
        mhdl_next  = mhdl_reg;
        mslot_next = mslot_reg;
        mok_next   = mok_reg;
        mlast_next = mlast_reg;

        we_valid = 1'b0;
        valid_d  = 1'b0;
        we_mode  = 1'b0;
        mode_d   = MODE_DEL;
        we_cd    = 1'b0;
        cd_d     = '0;
        we_cfg   = 1'b0;
        found    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = s_tuser;
                    hdl_next   = s_tdata[15:0];
                    per_next   = s_tdata[31:16];
                    typ_next   = in_typ;
                    idx_next   = '0;
                    ok_next    = 1'b0;
                    where_next = '0;
                    end_next   = in_end;
                    state_next = (in_end == '0) ? ST_FIN : ST_WALK;
                end
            end
            ST_WALK: begin
                if (out_free) begin
                    case (cmd_reg)
                        CMD_TICK: begin
                            if ((cur_mode == MODE_HANDLER || cur_mode == MODE_CYCLE)
                                && cd_reg[idx_reg] != '0) begin
                                we_cd = 1'b1;
                                if (cd_dec == '0) begin
                                    cd_d = {1'b0, period_reg[idx_reg]};
                                    if (cur_mode == MODE_HANDLER) begin
                                        mv_next    = 1'b1;
                                        mev_next   = EV_RUN;
                                        mhdl_next  = handle_reg[idx_reg];
                                        mslot_next = SLOT_W'(idx_reg);
                                        mok_next   = 1'b0;
                                        mlast_next = 1'b0;
                                    end else begin
                                        we_mode = 1'b1;
                                        mode_d  = MODE_READY;
                                    end
                                end else begin
                                    cd_d = cd_dec;
                                end
                            end
                        end
                        CMD_DISPATCH: begin
                            if (cur_mode == MODE_READY ||
                                (cur_mode == MODE_ONCE && valid_reg[idx_reg])) begin
                                we_mode    = 1'b1;
                                mode_d     = (cur_mode == MODE_READY) ? MODE_CYCLE : MODE_DEL;
                                mv_next    = 1'b1;
                                mev_next   = EV_RUN;
                                mhdl_next  = handle_reg[idx_reg];
                                mslot_next = SLOT_W'(idx_reg);
                                mok_next   = 1'b0;
                                mlast_next = 1'b0;
                            end
                        end
                        CMD_CREATE: begin
                            if (!valid_reg[idx_reg]) begin
                                found    = 1'b1;
                                we_valid = 1'b1;
                                valid_d  = 1'b1;
                                we_cfg   = 1'b1;
                                we_cd    = 1'b1;
                                cd_d     = {1'b0, per_reg} + CD_W'(1);
                                we_mode  = 1'b1;
                                case (typ_reg)
                                    TYPE_CYCLE:   mode_d = MODE_CYCLE;
                                    TYPE_HANDLER: mode_d = MODE_HANDLER;
                                    default:      mode_d = MODE_ONCE;
                                endcase
                                ok_next    = 1'b1;
                                where_next = idx_reg;
                                if (siu_reg <= CW'(idx_reg)) begin
                                    siu_next = CW'(idx_reg) + CW'(1);
                                end
                            end
                        end
                        default: begin
                            // delete: lowest valid slot with a matching handle
                            if (valid_reg[idx_reg] && handle_reg[idx_reg] == hdl_reg) begin
                                found      = 1'b1;
                                we_valid   = 1'b1;
                                valid_d    = 1'b0;
                                we_mode    = 1'b1;
                                mode_d     = MODE_DEL;
                                ok_next    = 1'b1;
                                where_next = idx_reg;
                                if (CW'(idx_reg) + CW'(1) == siu_reg) begin
                                    siu_next = siu_reg - CW'(1);
                                end
                            end
                        end
                    endcase
                    if (found || last_step) begin
                        state_next = ST_FIN;
                    end else begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    mv_next    = 1'b1;
                    mev_next   = EV_DONE;
                    mhdl_next  = (cmd_reg == CMD_CREATE || cmd_reg == CMD_DELETE) ?
                                 hdl_reg : '0;
                    mslot_next = SLOT_W'(where_reg);
                    mok_next   = ok_reg;
                    mlast_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            siu_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            siu_reg   <= siu_next;
            mv_reg    <= mv_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        end_reg   <= end_next;
        cmd_reg   <= cmd_next;
        hdl_reg   <= hdl_next;
        per_reg   <= per_next;
        typ_reg   <= typ_next;
        ok_reg    <= ok_next;
        where_reg <= where_next;
        mev_reg   <= mev_next;
        mhdl_reg  <= mhdl_next;
        mslot_reg <= mslot_next;
        mok_reg   <= mok_next;
        mlast_reg <= mlast_next;
    end

    // Slot state: valid and mode cleared on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
                mode_reg[i]  <= MODE_DEL;
            end
        end else begin
            if (we_valid) begin
                valid_reg[idx_reg] <= valid_d;
            end
            if (we_mode) begin
                mode_reg[idx_reg] <= mode_d;
            end
        end
    end

    // Slot payload: written before any read by create
    always_ff @(posedge aclk) begin
        if (we_cd) begin
            cd_reg[idx_reg] <= cd_d;
        end
        if (we_cfg) begin
            handle_reg[idx_reg] <= hdl_reg;
            period_reg[idx_reg] <= per_reg;
        end
    end

    // Result channel
    assign m_tvalid = mv_reg;
    assign m_tdata  = {4'b0000, mok_reg, mslot_reg, mhdl_reg};
    assign m_tuser  = mev_reg;
    assign m_tlast  = mlast_reg;

`include "periodic_task_slot_scheduler_defines.svh"

    `PTSS_ASSERT(a_siu_bound, siu_reg <= CW'(SLOTS), "in-use count exceeds slot count")
    `PTSS_ASSERT(a_last_is_done, m_tvalid |-> (m_tlast == m_tuser[0]), "tlast/kind mismatch")
    `PTSS_ASSERT(a_ok_only_last, (m_tvalid && m_tdata[19]) |-> m_tlast, "success on run event")
    `PTSS_ASSERT(a_busy_after_in, (s_tvalid && s_tready) |=> !s_tready, "ready after transfer")

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ptss_pkg::*;

    localparam int SLOTS = 8;
    localparam int CYCLE_LIMIT = 400000;

    // one result as the DUT should report it
    typedef struct packed {
        logic        ev;
        logic [15:0] hnd;
        logic [2:0]  idx;
        logic        ok;
        logic        lst;
    } sched_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic m_tlast;

    // shadow copy of the slot table
    bit          slot_used [SLOTS];
    logic [15:0] slot_hnd  [SLOTS];
    mode_t       slot_md   [SLOTS];
    logic [16:0] slot_cd   [SLOTS];
    logic [15:0] slot_per  [SLOTS];
    int unsigned used_cnt;

    sched_result_t due_results[$];
    int err_count = 0;
    int cycle_count = 0;
    bit no_stall = 1'b0;
    int ready_hold = 0;

    periodic_task_slot_scheduler #(
        .SLOTS(SLOTS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // idle length: mostly short, now and then a long one
    function automatic int rand_gap();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(8, 40);
        end
        return $urandom_range(1, 3);
    endfunction

    function automatic void push_result(logic ev, logic [15:0] hnd, int idx, bit ok, bit lst);
        sched_result_t r;
        r.ev  = ev;
        r.hnd = hnd;
        r.idx = idx[2:0];
        r.ok  = ok;
        r.lst = lst;
        due_results.push_back(r);
    endfunction

    // apply one command to the shadow table and queue what it must produce
    function automatic void advance_slot_table(logic [1:0] cmd, logic [15:0] hnd,
                                               logic [15:0] per, logic [1:0] ttype);
        int unsigned lim;
        int i;
        bit ok;
        int where;
        lim = (used_cnt > SLOTS) ? SLOTS : used_cnt;
        ok = 1'b0;
        where = 0;
        case (cmd)
            CMD_TICK: begin
                for (i = 0; i < lim; i++) begin
                    if ((slot_md[i] == MODE_HANDLER || slot_md[i] == MODE_CYCLE) &&
                        slot_cd[i] != '0) begin
                        slot_cd[i] = slot_cd[i] - 1'b1;
                        if (slot_cd[i] == '0) begin
                            slot_cd[i] = {1'b0, slot_per[i]};
                            if (slot_md[i] == MODE_HANDLER) begin
                                push_result(EV_RUN, slot_hnd[i], i, 1'b0, 1'b0);
                            end else begin
                                slot_md[i] = MODE_READY;
                            end
                        end
                    end
                end
                push_result(EV_DONE, '0, 0, 1'b0, 1'b1);
            end
            CMD_DISPATCH: begin
                for (i = 0; i < lim; i++) begin
                    if (slot_md[i] == MODE_READY) begin
                        slot_md[i] = MODE_CYCLE;
                        push_result(EV_RUN, slot_hnd[i], i, 1'b0, 1'b0);
                    end else if (slot_md[i] == MODE_ONCE && slot_used[i]) begin
                        slot_md[i] = MODE_DEL;
                        push_result(EV_RUN, slot_hnd[i], i, 1'b0, 1'b0);
                    end
                end
                push_result(EV_DONE, '0, 0, 1'b0, 1'b1);
            end
            CMD_CREATE: begin
                if (ttype != TYPE_BAD) begin
                    for (i = 0; i < SLOTS && !ok; i++) begin
                        if (!slot_used[i]) begin
                            if (used_cnt <= i) used_cnt = i + 1;
                            slot_used[i] = 1'b1;
                            slot_hnd[i]  = hnd;
                            slot_cd[i]   = {1'b0, per} + 17'd1;
                            slot_per[i]  = per;
                            slot_md[i]   = (ttype == TYPE_CYCLE)   ? MODE_CYCLE :
                                           (ttype == TYPE_HANDLER) ? MODE_HANDLER : MODE_ONCE;
                            ok = 1'b1;
                            where = i;
                        end
                    end
                end
                push_result(EV_DONE, hnd, where, ok, 1'b1);
            end
            default: begin
                // delete: lowest in-use slot with a matching handle
                for (i = 0; i < lim && !ok; i++) begin
                    if (slot_used[i] && slot_hnd[i] == hnd) begin
                        if (i + 1 == used_cnt) used_cnt = used_cnt - 1;
                        slot_used[i] = 1'b0;
                        slot_md[i]   = MODE_DEL;
                        ok = 1'b1;
                        where = i;
                    end
                end
                push_result(EV_DONE, hnd, where, ok, 1'b1);
            end
        endcase
    endfunction

    // one command transfer; valid stays high after acceptance until the next call
    task automatic send_cmd(input logic [1:0] cmd, input logic [15:0] hnd,
                            input logic [15:0] per, input logic [1:0] ttype);
        int gap;
        gap = (no_stall || $urandom_range(0, 1) == 0) ? 0 : rand_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tuser  <= cmd;
        s_tdata  <= {6'b0, ttype, per, hnd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_slot_table(cmd, hnd, per, ttype);
    endtask

    // hold the input side off until everything owed has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic test_create_types();
        send_cmd(CMD_CREATE, 16'h0000, 16'd0,      TYPE_CYCLE);
        send_cmd(CMD_CREATE, 16'hFFFF, 16'hFFFF,   TYPE_HANDLER);
        send_cmd(CMD_CREATE, 16'h1234, 16'd1,      TYPE_HANDLER);
        send_cmd(CMD_CREATE, 16'h5A5A, 16'd2,      TYPE_ONCE);
        send_cmd(CMD_CREATE, 16'h7777, 16'd3,      TYPE_BAD);
    endtask

    // expiry of period 0 and 1, handler run events, ready and once dispatch
    task automatic test_countdown_dispatch();
        send_cmd(CMD_TICK,     16'hA5A5, 16'h5A5A, TYPE_BAD);
        send_cmd(CMD_TICK,     16'h0000, 16'h0000, TYPE_CYCLE);
        send_cmd(CMD_DISPATCH, 16'hFFFF, 16'hFFFF, TYPE_BAD);
        send_cmd(CMD_TICK,     16'h0F0F, 16'hF0F0, TYPE_ONCE);
        send_cmd(CMD_DISPATCH, 16'h0000, 16'h0000, TYPE_CYCLE);
    endtask

    // duplicate handle, fill the table, retired once slot still blocks create
    task automatic test_table_full();
        send_cmd(CMD_CREATE, 16'h1234, 16'd5, TYPE_CYCLE);
        send_cmd(CMD_CREATE, 16'hA5A5, 16'd2, TYPE_HANDLER);
        send_cmd(CMD_CREATE, 16'hA5A5, 16'd1, TYPE_CYCLE);
        send_cmd(CMD_CREATE, 16'h0F0F, 16'd4, TYPE_HANDLER);
        send_cmd(CMD_CREATE, 16'hBEEF, 16'd1, TYPE_CYCLE);
    endtask

    task automatic test_delete_cases();
        send_cmd(CMD_DELETE, 16'h1234, 16'd0, TYPE_CYCLE);
        send_cmd(CMD_DELETE, 16'hCAFE, 16'd0, TYPE_CYCLE);
        send_cmd(CMD_DELETE, 16'h0F0F, 16'd0, TYPE_CYCLE);
        send_cmd(CMD_CREATE, 16'h2222, 16'd0, TYPE_ONCE);
        send_cmd(CMD_DELETE, 16'h5A5A, 16'd0, TYPE_CYCLE);
        send_cmd(CMD_DISPATCH, 16'h0000, 16'd0, TYPE_CYCLE);
        send_cmd(CMD_TICK, 16'h0000, 16'd0, TYPE_CYCLE);
    endtask

    // mixed traffic over a small handle pool so deletes mostly hit
    task automatic test_random_traffic(input int count);
        logic [15:0] pool [8];
        logic [1:0]  cmd;
        logic [15:0] hnd;
        logic [15:0] per;
        logic [1:0]  ttype;
        int k;
        int r;
        int s;
        for (k = 0; k < 8; k++) pool[k] = $urandom;
        for (k = 0; k < count; k++) begin
            if (k == count / 2) drain_results();
            no_stall = (k >= count * 5 / 8 && k < count * 13 / 16);
            r = $urandom_range(0, 99);
            cmd = (r < 40) ? CMD_TICK : (r < 60) ? CMD_DISPATCH :
                  (r < 80) ? CMD_CREATE : CMD_DELETE;
            hnd = ($urandom_range(0, 3) == 0) ? 16'($urandom) : pool[$urandom_range(0, 7)];
            per = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
            ttype = ($urandom_range(0, 15) == 0) ? TYPE_BAD : 2'($urandom_range(0, 2));
            if (cmd == CMD_DELETE) begin
                s = $urandom_range(0, SLOTS - 1);
                if (slot_used[s] && $urandom_range(0, 3) != 0) hnd = slot_hnd[s];
            end
            send_cmd(cmd, hnd, per, ttype);
        end
        no_stall = 1'b0;
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            err_count++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        sched_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $error("result transfer with nothing outstanding: tdata 0x%0h", m_tdata);
                err_count++;
            end else begin
                want = due_results.pop_front();
                check_field("event_res",  want.ev,  m_tuser[0]);
                check_field("run_handle", want.hnd, m_tdata[15:0]);
                check_field("slot_index", want.idx, m_tdata[18:16]);
                check_field("success",    want.ok,  m_tdata[19]);
                check_field("last",       want.lst, m_tlast);
            end
        end
    end

    // downstream backpressure
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (no_stall || $urandom_range(0, 2) != 0) begin
            m_tready   <= 1'b1;
            ready_hold <= $urandom_range(0, 6);
        end else begin
            m_tready   <= 1'b0;
            ready_hold <= rand_gap();
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("periodic_task_slot_scheduler regression: fail");
            $finish;
        end
    end

    initial begin
        int i;
        for (i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_hnd[i]  = '0;
            slot_md[i]   = MODE_DEL;
            slot_cd[i]   = '0;
            slot_per[i]  = '0;
        end
        used_cnt = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_create_types();
        test_countdown_dispatch();
        test_table_full();
        test_delete_cases();
        test_random_traffic(138);

        drain_results();
        repeat (SLOTS + 4) @(posedge aclk);
        if (err_count == 0 && due_results.size() == 0) begin
            $display("periodic_task_slot_scheduler regression: pass");
        end else begin
            $display("periodic_task_slot_scheduler regression: fail");
        end
        $finish;
    end

endmodule
